// ----- rtl/ltc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltc_pkg
// Shared types, constants and character helpers for the literal token
// classifier.
// ----------------------------------------------------------------------------
package ltc_pkg;

    localparam int CP_W    = 21;
    localparam int COUNT_W = 3;
    localparam int CLASS_W = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 3'd6;

    localparam logic [CP_W-1:0] CH_LF      = 21'h0000A;
    localparam logic [CP_W-1:0] CH_CR      = 21'h0000D;
    localparam logic [CP_W-1:0] CH_LS      = 21'h02028;
    localparam logic [CP_W-1:0] CH_PS      = 21'h02029;
    localparam logic [CP_W-1:0] CH_DQUOTE  = 21'h00022;
    localparam logic [CP_W-1:0] CH_SQUOTE  = 21'h00027;
    localparam logic [CP_W-1:0] CH_PLUS    = 21'h0002B;
    localparam logic [CP_W-1:0] CH_MINUS   = 21'h0002D;
    localparam logic [CP_W-1:0] CH_DOT     = 21'h0002E;
    localparam logic [CP_W-1:0] CH_ZERO    = 21'h00030;
    localparam logic [CP_W-1:0] CH_NINE    = 21'h00039;

    typedef enum logic [1:0] {
        INT_START,
        INT_SIGN,
        INT_DIGITS,
        INT_DEAD
    } t_int_state;

    typedef enum logic [1:0] {
        FLT_START,
        FLT_PRE,
        FLT_POST,
        FLT_DEAD
    } t_flt_state;

    typedef enum logic [CLASS_W-1:0] {
        CLS_INVALID = 3'd0,
        CLS_INTEGER = 3'd1,
        CLS_FLOAT   = 3'd2,
        CLS_CHAR    = 3'd3,
        CLS_STRING  = 3'd4,
        CLS_BOOLEAN = 3'd5
    } t_class;

    typedef struct packed {
        logic digit;
        logic sign;
        logic dot;
        logic squote;
        logic dquote;
        logic term;
        logic true_hit;
        logic false_hit;
    } t_char_flags;

    // letter of "true" at a position, positions past the word never match
    function automatic logic word_true_hit(logic [COUNT_W-1:0] pos, logic [CP_W-1:0] cp);
        logic hit;
        unique case (pos)
            3'd0:    hit = (cp == 21'h00074);
            3'd1:    hit = (cp == 21'h00072);
            3'd2:    hit = (cp == 21'h00075);
            3'd3:    hit = (cp == 21'h00065);
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic word_false_hit(logic [COUNT_W-1:0] pos, logic [CP_W-1:0] cp);
        logic hit;
        unique case (pos)
            3'd0:    hit = (cp == 21'h00066);
            3'd1:    hit = (cp == 21'h00061);
            3'd2:    hit = (cp == 21'h0006C);
            3'd3:    hit = (cp == 21'h00073);
            3'd4:    hit = (cp == 21'h00065);
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

// ----- rtl/ltc_char_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltc_char_decode
// Decodes one code point into the character-class flags used by the
// pattern trackers.
// ----------------------------------------------------------------------------
module ltc_char_decode
    import ltc_pkg::*;
(
    input  logic [CP_W-1:0]    i_code_point,
    input  logic [COUNT_W-1:0] i_pos,
    output t_char_flags        o_flags
);

    always_comb begin
        o_flags.digit     = (i_code_point >= CH_ZERO) && (i_code_point <= CH_NINE);
        o_flags.sign      = (i_code_point == CH_PLUS) || (i_code_point == CH_MINUS);
        o_flags.dot       = (i_code_point == CH_DOT);
        o_flags.squote    = (i_code_point == CH_SQUOTE);
        o_flags.dquote    = (i_code_point == CH_DQUOTE);
        o_flags.term      = (i_code_point == CH_LF) || (i_code_point == CH_CR) ||
                            (i_code_point == CH_LS) || (i_code_point == CH_PS);
        o_flags.true_hit  = word_true_hit(i_pos, i_code_point);
        o_flags.false_hit = word_false_hit(i_pos, i_code_point);
    end

endmodule

// ----- rtl/ltc_tracker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltc_tracker
// Per-token pattern state: integer and float recognizers, quote, terminator
// and keyword flags, character count. Produces the class on the last char.
// ----------------------------------------------------------------------------
module ltc_tracker
    import ltc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic               i_is_last,
    input  logic               i_is_empty,
    input  t_char_flags        i_flags,
    output logic [COUNT_W-1:0] o_pos,
    output t_class             o_class
);

    t_int_state         r_int, n_int;
    t_flt_state         r_flt, n_flt;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_sq, n_sq;
    logic               r_dq, n_dq;
    logic               r_term, n_term;
    logic               r_tm, n_tm;
    logic               r_fm, n_fm;

    t_int_state ist;
    t_flt_state fst;
    logic       term, tm, fm, sq0, dq0;
    logic       first;

    assign o_pos = r_count;
    assign first = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int   <= INT_START;
            r_flt   <= FLT_START;
            r_count <= '0;
            r_sq    <= 1'b0;
            r_dq    <= 1'b0;
            r_term  <= 1'b0;
            r_tm    <= 1'b1;
            r_fm    <= 1'b1;
        end else begin
            r_int   <= n_int;
            r_flt   <= n_flt;
            r_count <= n_count;
            r_sq    <= n_sq;
            r_dq    <= n_dq;
            r_term  <= n_term;
            r_tm    <= n_tm;
            r_fm    <= n_fm;
        end
    end

    always_comb begin
        unique case (r_int)
            INT_START: begin
                if (i_flags.sign) begin
                    ist = INT_SIGN;
                end else if (i_flags.digit) begin
                    ist = INT_DIGITS;
                end else begin
                    ist = INT_DEAD;
                end
            end
            INT_SIGN, INT_DIGITS: ist = i_flags.digit ? INT_DIGITS : INT_DEAD;
            default:              ist = INT_DEAD;
        endcase

        unique case (r_flt)
            FLT_START: begin
                if (i_flags.sign || i_flags.digit) begin
                    fst = FLT_PRE;
                end else if (i_flags.dot) begin
                    fst = FLT_POST;
                end else begin
                    fst = FLT_DEAD;
                end
            end
            FLT_PRE: begin
                if (i_flags.digit) begin
                    fst = FLT_PRE;
                end else if (i_flags.dot) begin
                    fst = FLT_POST;
                end else begin
                    fst = FLT_DEAD;
                end
            end
            FLT_POST: fst = i_flags.digit ? FLT_POST : FLT_DEAD;
            default:  fst = FLT_DEAD;
        endcase

        term = r_term || i_flags.term;
        tm   = r_tm && i_flags.true_hit;
        fm   = r_fm && i_flags.false_hit;
        sq0  = first ? i_flags.squote : r_sq;
        dq0  = first ? i_flags.dquote : r_dq;

        priority if (ist == INT_DIGITS) begin
            o_class = CLS_INTEGER;
        end else if (fst != FLT_DEAD) begin
            o_class = CLS_FLOAT;
        end else if (!term && i_flags.squote &&
                     ((r_count == 3'd1) || ((r_count == 3'd2) && r_sq))) begin
            o_class = CLS_CHAR;
        end else if (!term && !first &&
                     ((r_dq && i_flags.dquote) || (r_sq && i_flags.squote))) begin
            o_class = CLS_STRING;
        end else if ((tm && (r_count == 3'd3)) || (fm && (r_count == 3'd4))) begin
            o_class = CLS_BOOLEAN;
        end else begin
            o_class = CLS_INVALID;
        end
        if (i_is_empty) begin
            o_class = CLS_INVALID;
        end

        n_int   = r_int;
        n_flt   = r_flt;
        n_count = r_count;
        n_sq    = r_sq;
        n_dq    = r_dq;
        n_term  = r_term;
        n_tm    = r_tm;
        n_fm    = r_fm;
        if (i_step) begin
            if (i_is_empty || i_is_last) begin
                n_int   = INT_START;
                n_flt   = FLT_START;
                n_count = '0;
                n_sq    = 1'b0;
                n_dq    = 1'b0;
                n_term  = 1'b0;
                n_tm    = 1'b1;
                n_fm    = 1'b1;
            end else begin
                n_int   = ist;
                n_flt   = fst;
                n_count = (r_count < COUNT_MAX) ? r_count + 3'd1 : r_count;
                n_sq    = sq0;
                n_dq    = dq0;
                n_term  = term;
                n_tm    = tm;
                n_fm    = fm;
            end
        end
    end

endmodule

// ----- rtl/literal_token_classifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// literal_token_classifier
// Classifies a character-serial token as invalid, integer, float, char,
// string or boolean.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one character request per cycle (i_code_point, i_is_last)
//   or an empty-token request (i_is_empty). A request is taken on a rising
//   edge with i_in_valid high and o_in_stall low.
//   Output channel: one o_token_class per token, delivered on the request
//   carrying the last character or the empty mark; taken when o_out_valid is
//   high and i_out_stall is low.
//   Result path: the last character enters the input register, then its
//   class the result register, where o_out_valid rises and it can be taken.
//   Throughput: one character per cycle while o_in_stall is low, limited by
//   the single pass through the character decode and tracker update
//   between the two registers.
//   Reset (synchronous, i_rst_n low): both registers empty, token state back
//   to the start of a token.
//   Receiver stall: the result register holds; the input register still
//   takes characters that give no result, and o_in_stall rises only while a
//   finishing character waits for the result register.
// ----------------------------------------------------------------------------
module literal_token_classifier
    import ltc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [CP_W-1:0]    i_code_point,
    input  logic               i_is_last,
    input  logic               i_is_empty,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [CLASS_W-1:0] o_token_class
);

    logic            r_in_valid;
    logic [CP_W-1:0] r_cp;
    logic            r_last;
    logic            r_empty;

    logic         r_out_valid;
    t_class       r_class;

    logic               produces;
    logic               out_free;
    logic               step;
    logic               accept;
    logic [COUNT_W-1:0] pos;
    t_char_flags        flags;
    t_class             cls;

    assign produces    = r_last || r_empty;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign step        = r_in_valid && (!produces || out_free);
    assign o_in_stall  = r_in_valid && !step;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_token_class = r_class;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept || (r_in_valid && !step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cp    <= i_code_point;
            r_last  <= i_is_last;
            r_empty <= i_is_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && produces) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && produces) begin
            r_class <= cls;
        end
    end

    ltc_char_decode u_decode (
        .i_code_point (r_cp),
        .i_pos        (pos),
        .o_flags      (flags)
    );

    ltc_tracker u_tracker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_is_last  (r_last),
        .i_is_empty (r_empty),
        .i_flags    (flags),
        .o_pos      (pos),
        .o_class    (cls)
    );

endmodule
